>>> src/mme_pkg.sv
package mme_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ElemW  = 16;
  localparam int unsigned AccW   = 48;
  localparam int unsigned DimW   = 4;
  localparam int unsigned CfgIdxW = 2;

  // Operation codes
  localparam logic [OpW-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OpW-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLS_B    = 2'd2;

  // Reset value of every dimension register
  localparam logic [DimW-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [ElemW-1:0] element;
  } mme_in_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_row;
    logic [IdxW-1:0]        out_col;
    logic signed [AccW-1:0] product_value;
    logic                   last;
  } mme_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            wr_a;     // store element into A
    logic            wr_b;     // store element into B
    logic [IdxW-1:0] wr_row;
    logic [IdxW-1:0] wr_col;
    logic            mac_vld;  // issue one multiply-accumulate step
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] k;
    logic            first;    // first step of a dot product: clear accumulator
    logic            fin;      // final step of a dot product: emit
    logic            zero;     // empty inner dimension: force product to zero
    logic            last;     // final element of the compute
  } mme_cmd_t;

endpackage

>>> src/mme_ram.sv
module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mme_ctrl.sv
module mme_ctrl import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mme_in_t            in_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output mme_cmd_t           cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  logic            state_q, state_d;
  logic [DimW-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DimW-1:0] ra_eff, kd_eff, cb_eff;
  logic [DimW-1:0] ra_q, ra_d, kd_q, kd_d, cb_q, cb_d;
  logic            zero_q, zero_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            accept;
  logic            k_end, j_end, i_end;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == ST_RUN);
  assign accept      = start && !busy;

  // Saturate the dimension registers to the array size
  assign ra_eff = (rows_a_q > MaxDim) ? MaxDim : rows_a_q;
  assign kd_eff = (inner_dim_q > MaxDim) ? MaxDim : inner_dim_q;
  assign cb_eff = (cols_b_q > MaxDim) ? MaxDim : cols_b_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Loop end conditions of the current step
  assign k_end = zero_q || (({1'b0, k_q} + 4'd1) == kd_q);
  assign j_end = (({1'b0, j_q} + 4'd1) == cb_q);
  assign i_end = (({1'b0, i_q} + 4'd1) == ra_q);

  // Sequence rows, columns and inner steps
  always_comb begin
    state_d = state_q;
    ra_d    = ra_q;
    kd_d    = kd_q;
    cb_d    = cb_q;
    zero_d  = zero_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.op == OP_COMPUTE) && (ra_eff != '0) && (cb_eff != '0)) begin
          state_d = ST_RUN;
          ra_d    = ra_eff;
          kd_d    = kd_eff;
          cb_d    = cb_eff;
          zero_d  = (kd_eff == '0);
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (k_end) begin
          k_d = '0;
          if (j_end) begin
            j_d = '0;
            if (i_end) begin
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + IdxW'(1);
            end
          end else begin
            j_d = j_q + IdxW'(1);
          end
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    kd_q   <= kd_d;
    cb_q   <= cb_d;
    zero_q <= zero_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
  end

  // Drive commands: loads write at acceptance, compute steps issue while running
  always_comb begin
    cmd_o.wr_a    = accept && (in_i.op == OP_LOAD_A) &&
                    ({1'b0, in_i.row_index} < ra_eff) && ({1'b0, in_i.col_index} < kd_eff);
    cmd_o.wr_b    = accept && (in_i.op == OP_LOAD_B) &&
                    ({1'b0, in_i.row_index} < kd_eff) && ({1'b0, in_i.col_index} < cb_eff);
    cmd_o.wr_row  = in_i.row_index;
    cmd_o.wr_col  = in_i.col_index;
    cmd_o.mac_vld = (state_q == ST_RUN);
    cmd_o.row     = i_q;
    cmd_o.col     = j_q;
    cmd_o.k       = k_q;
    cmd_o.first   = (k_q == '0);
    cmd_o.fin     = k_end;
    cmd_o.zero    = zero_q;
    cmd_o.last    = k_end && j_end && i_end;
  end

endmodule

>>> src/mme_dp.sv
module mme_dp import mme_pkg::*; #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mme_cmd_t                cmd_i,
  input  logic signed [ElemW-1:0] element_i,
  output logic                    out_valid_o,
  output mme_out_t                out_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0]        wdata;
  logic [AddrW-1:0]             waddr, a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0]        a_rdata, b_rdata;
  logic signed [ProdW-1:0]      prod;
  logic signed [AccW-1:0]       prod_ext;
  logic signed [AccW-1:0]       prod_q;
  logic signed [AccW-1:0]       acc_q, acc_d;
  mme_cmd_t                     s1_q, s2_q;
  logic                         s1_vld_q, s2_vld_q;
  logic                         out_valid_q;
  mme_out_t                     out_q;

  // Fit the loaded element to the store width
  if (DATA_WIDTH <= ElemW) begin : g_wr_trunc
    assign wdata = element_i[DATA_WIDTH-1:0];
  end else begin : g_wr_sext
    assign wdata = {{(DATA_WIDTH-ElemW){element_i[ElemW-1]}}, element_i};
  end

  assign waddr   = AddrW'(cmd_i.wr_row * MAX_DIM + cmd_i.wr_col);
  assign a_raddr = AddrW'(cmd_i.row * MAX_DIM + cmd_i.k);
  assign b_raddr = AddrW'(cmd_i.k * MAX_DIM + cmd_i.col);

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mac_vld),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mac_vld),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Multiply the two read operands
  assign prod = $signed(a_rdata) * $signed(b_rdata);

  if (ProdW >= AccW) begin : g_prod_trunc
    assign prod_ext = prod[AccW-1:0];
  end else begin : g_prod_sext
    assign prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};
  end

  // Accumulate, restarting on the first step of each dot product
  assign acc_d = (s2_q.first ? '0 : acc_q) + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_vld_q    <= cmd_i.mac_vld;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= s2_vld_q && s2_q.fin;
    end
  end

  // Advance step tags and data through the pipeline
  always_ff @(posedge clk_i) begin
    s1_q   <= cmd_i;
    s2_q   <= s1_q;
    prod_q <= s1_q.zero ? '0 : prod_ext;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (s2_vld_q && s2_q.fin) begin
      out_q.out_row       <= s2_q.row;
      out_q.out_col       <= s2_q.col;
      out_q.product_value <= acc_d;
      out_q.last          <= s2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> src/matrix_multiply_engine.sv
// Channel   Handshake                      Payload
// -------   ----------------------------   ---------------------------------------------
// input     start & !busy                  in_i  (op, row_index, col_index, element)
// result    out_valid_o, one-cycle strobe  out_o (out_row, out_col, product_value, last)
// config    cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// A load leaves busy low, so loads stream one per cycle while no compute runs.
// A compute holds busy while it steps through every row, column and inner index,
// one multiply-accumulate per cycle through the A and B store read ports;
// each result passes the read, product and output registers after its last step.
// Reset clears control state and sets every dimension to 8; stores are not
// cleared. The receiver cannot stall: every result strobe is taken.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mme_in_t            in_i,
  output logic               out_valid_o,
  output mme_out_t           out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  mme_cmd_t cmd;

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd)
  );

  mme_dp #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .element_i   (in_i.element),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

>>> tb/sv/matrix_multiply_engine_tb.sv
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam int TB_DIM       = 8;
  localparam int ITEM_GOAL    = 340;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 5000;

  // Index past the last dimension register; writes to it change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  // Op code with no operation; the block drops it
  localparam logic [OpW-1:0] OP_SPARE = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  mme_in_t            in_i        = '0;
  logic               out_valid_o;
  mme_out_t           out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DimW-1:0]    cfg_data_i  = '0;

  matrix_multiply_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting for the driver, and C elements still to come out
  mme_in_t  pending_cmds[$];
  mme_out_t expected_products[$];

  // Shadow of the dimension registers and of the A and B stores
  logic [DimW-1:0]         dim_reg [3] = '{DIM_RESET, DIM_RESET, DIM_RESET};
  logic signed [ElemW-1:0] a_mem [TB_DIM*TB_DIM];
  logic signed [ElemW-1:0] b_mem [TB_DIM*TB_DIM];

  // Entries that queued loads will have written; computes never touch others
  bit a_set [TB_DIM*TB_DIM];
  bit b_set [TB_DIM*TB_DIM];

  int idle_pct      = 32;
  int useful_items  = 0;
  int load_count    = 0;
  int compute_count = 0;
  int checked_count = 0;
  int dim_writes    = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  function automatic int eff_dim(logic [DimW-1:0] d);
    return (d > TB_DIM) ? TB_DIM : int'(d);
  endfunction

  // Apply one accepted transaction to the shadow state; queue the C elements
  function automatic void predict_products(mme_in_t it);
    int ra;
    int kd;
    int cb;
    logic signed [AccW-1:0] acc;
    mme_out_t res;
    ra = eff_dim(dim_reg[CFG_ROWS_A]);
    kd = eff_dim(dim_reg[CFG_INNER_DIM]);
    cb = eff_dim(dim_reg[CFG_COLS_B]);
    case (it.op)
      OP_LOAD_A: begin
        load_count++;
        if (it.row_index < ra && it.col_index < kd) a_mem[{it.row_index, it.col_index}] = it.element;
      end
      OP_LOAD_B: begin
        load_count++;
        if (it.row_index < kd && it.col_index < cb) b_mem[{it.row_index, it.col_index}] = it.element;
      end
      OP_COMPUTE: begin
        compute_count++;
        for (int i = 0; i < ra; i++) begin
          for (int j = 0; j < cb; j++) begin
            acc = '0;
            for (int k = 0; k < kd; k++) acc = acc + a_mem[i*TB_DIM+k] * b_mem[k*TB_DIM+j];
            res.out_row       = IdxW'(i);
            res.out_col       = IdxW'(j);
            res.product_value = acc;
            res.last          = (i == ra - 1) && (j == cb - 1);
            expected_products.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic mme_in_t make_item(logic [OpW-1:0] op, int r, int c, logic [ElemW-1:0] e);
    mme_in_t it;
    it.op        = op;
    it.row_index = IdxW'(r);
    it.col_index = IdxW'(c);
    it.element   = e;
    return it;
  endfunction

  // Mix the corner values of a Q8.8 element in with random ones
  function automatic logic [ElemW-1:0] pick_element();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0001;
      4: return 16'h0000;
      default: return ElemW'($urandom);
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return DimW'($urandom_range(15, 9));
      2: return DimW'(TB_DIM);
      default: return DimW'($urandom_range(4, 1));
    endcase
  endfunction

  // Queue a command and track which store entries it will write
  function automatic void queue_item(mme_in_t it);
    int ra;
    int kd;
    int cb;
    ra = eff_dim(dim_reg[CFG_ROWS_A]);
    kd = eff_dim(dim_reg[CFG_INNER_DIM]);
    cb = eff_dim(dim_reg[CFG_COLS_B]);
    pending_cmds.push_back(it);
    case (it.op)
      OP_LOAD_A: begin
        if (it.row_index < ra && it.col_index < kd) begin
          a_set[{it.row_index, it.col_index}] = 1'b1;
          useful_items++;
        end
      end
      OP_LOAD_B: begin
        if (it.row_index < kd && it.col_index < cb) begin
          b_set[{it.row_index, it.col_index}] = 1'b1;
          useful_items++;
        end
      end
      OP_COMPUTE: useful_items++;
      default: ;
    endcase
  endfunction

  // Fill any entry the compute would read that was never written, then compute
  function automatic void queue_compute();
    int ra;
    int kd;
    int cb;
    ra = eff_dim(dim_reg[CFG_ROWS_A]);
    kd = eff_dim(dim_reg[CFG_INNER_DIM]);
    cb = eff_dim(dim_reg[CFG_COLS_B]);
    if (ra != 0 && cb != 0) begin
      for (int i = 0; i < ra; i++)
        for (int k = 0; k < kd; k++)
          if (!a_set[i*TB_DIM+k]) queue_item(make_item(OP_LOAD_A, i, k, pick_element()));
      for (int k = 0; k < kd; k++)
        for (int j = 0; j < cb; j++)
          if (!b_set[k*TB_DIM+j]) queue_item(make_item(OP_LOAD_B, k, j, pick_element()));
    end
    queue_item(make_item(OP_COMPUTE, $urandom_range(7), $urandom_range(7), ElemW'($urandom)));
  endfunction

  // Write one dimension register; only called while the block is idle
  task automatic write_dim(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx != CFG_SPARE) dim_reg[idx] = val;
    dim_writes++;
  endtask

  // Wait until every command is taken and every C element has come out
  task automatic settle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || busy || expected_products.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: hold a command until taken, then present the next or idle
  always @(posedge clk_i) begin
    logic slot_free;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) predict_products(in_i);
      if (slot_free) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_i  <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each C element against the oldest expectation
  always @(posedge clk_i) begin
    mme_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o) begin
        if (expected_products.size() == 0) begin
          $display("%0t unexpected result row %0d col %0d value %0d last %0b", $time,
                   out_o.out_row, out_o.out_col, out_o.product_value, out_o.last);
          fail_count++;
        end else begin
          want = expected_products.pop_front();
          checked_count++;
          if (out_o.out_row !== want.out_row || out_o.out_col !== want.out_col ||
              out_o.product_value !== want.product_value || out_o.last !== want.last) begin
            $display("%0t mismatch expected row %0d col %0d value %0d last %0b", $time,
                     want.out_row, want.out_col, want.product_value, want.last);
            $display("%0t          actual   row %0d col %0d value %0d last %0b", $time,
                     out_o.out_row, out_o.out_col, out_o.product_value, out_o.last);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[matrix_multiply_engine] ERROR");
    $finish;
  end

  initial begin
    int roll;
    int ra;
    int kd;
    int cb;
    int rmax;
    int cmax;
    bit is_b;
    logic [OpW-1:0] noise_op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-element products at the extremes of Q8.8
    write_dim(CFG_ROWS_A, 4'd1);
    write_dim(CFG_INNER_DIM, 4'd1);
    write_dim(CFG_COLS_B, 4'd1);
    queue_item(make_item(OP_LOAD_A, 0, 0, 16'h8000));
    queue_item(make_item(OP_LOAD_B, 0, 0, 16'h8000));
    queue_compute();
    queue_item(make_item(OP_LOAD_A, 0, 0, 16'h7fff));
    queue_compute();
    queue_item(make_item(OP_LOAD_B, 0, 0, 16'h7fff));
    queue_compute();
    // Unused op and loads outside the current dimensions: all dropped
    queue_item(make_item(OP_SPARE, 7, 7, 16'hffff));
    queue_item(make_item(OP_LOAD_A, 7, 7, 16'h1234));
    queue_item(make_item(OP_LOAD_A, 0, 1, 16'h4321));
    queue_item(make_item(OP_LOAD_B, 0, 1, 16'h5555));
    queue_item(make_item(OP_LOAD_B, 1, 0, 16'haaaa));
    queue_compute();
    queue_item(make_item(OP_LOAD_A, 0, 0, 16'hffff));
    queue_item(make_item(OP_LOAD_B, 0, 0, 16'h0001));
    queue_compute();
    settle();

    // Zero inner dimension gives zero sums; zero rows or columns give nothing
    write_dim(CFG_INNER_DIM, 4'd0);
    queue_compute();
    settle();
    write_dim(CFG_ROWS_A, 4'd0);
    queue_compute();
    settle();
    write_dim(CFG_ROWS_A, 4'd1);
    write_dim(CFG_COLS_B, 4'd0);
    write_dim(CFG_SPARE, 4'hf);
    queue_compute();
    settle();

    // Random phases: mostly in-range loads and computes, some noise
    while (useful_items < ITEM_GOAL) begin
      idle_pct = (useful_items < ITEM_GOAL / 3) ? 32 : (useful_items < 2 * ITEM_GOAL / 3) ? 64 : 0;
      write_dim(CFG_ROWS_A, pick_dim());
      write_dim(CFG_INNER_DIM, pick_dim());
      write_dim(CFG_COLS_B, pick_dim());
      ra = eff_dim(dim_reg[CFG_ROWS_A]);
      kd = eff_dim(dim_reg[CFG_INNER_DIM]);
      cb = eff_dim(dim_reg[CFG_COLS_B]);
      repeat ($urandom_range(40, 15)) begin
        roll = $urandom_range(99);
        if (roll < 62) begin
          is_b = $urandom_range(1);
          rmax = is_b ? kd : ra;
          cmax = is_b ? cb : kd;
          if (rmax != 0 && cmax != 0)
            queue_item(make_item(is_b ? OP_LOAD_B : OP_LOAD_A, $urandom_range(rmax - 1),
                                 $urandom_range(cmax - 1), pick_element()));
        end else if (roll < 80) begin
          queue_compute();
        end else begin
          noise_op = OpW'($urandom_range(3));
          if (noise_op == OP_COMPUTE) queue_compute();
          else queue_item(make_item(noise_op, $urandom_range(7), $urandom_range(7), pick_element()));
        end
      end
      settle();
    end

    // Saturating registers, full 8x8x8 of the most negative element
    write_dim(CFG_ROWS_A, 4'd15);
    write_dim(CFG_INNER_DIM, 4'd9);
    write_dim(CFG_COLS_B, 4'd12);
    for (int r = 0; r < TB_DIM; r++)
      for (int c = 0; c < TB_DIM; c++) begin
        queue_item(make_item(OP_LOAD_A, r, c, 16'h8000));
        queue_item(make_item(OP_LOAD_B, r, c, 16'h8000));
      end
    queue_compute();
    settle();

    $display("run covered %0d loads and %0d computes, %0d C elements checked",
             load_count, compute_count, checked_count);
    $display("dimension registers written %0d times, %0d mismatches", dim_writes, fail_count);
    if (fail_count == 0) begin
      $display("[matrix_multiply_engine] OK");
    end else begin
      $display("[matrix_multiply_engine] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mme_pkg.sv
src/mme_ram.sv
src/mme_ctrl.sv
src/mme_dp.sv
src/matrix_multiply_engine.sv
tb/sv/matrix_multiply_engine_tb.sv
